@@ hdl/rcbp_pkg.sv @@
// shared constants and codes of the reference-counted block pool
package rcbp_pkg;

    // fixed payload widths
    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 16;
    localparam int FREE_OUT_W = 9;

    // default sizing
    localparam int DEF_SLOTS      = 256;
    localparam int DEF_COUNT_BITS = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_GET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REF = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PUT = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_IN_USE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SATURATED  = 2'd3;

endpackage

@@ hdl/rcbp_req_if.sv @@
// request channel of the block pool: operation and slot
interface rcbp_req_if import rcbp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot_in;

    modport source (output valid, output func, output slot_in, input ready);
    modport sink   (input valid, input func, input slot_in, output ready);

endinterface

@@ hdl/rcbp_rsp_if.sv @@
// response channel of the block pool: status, slot and counts
interface rcbp_rsp_if import rcbp_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot_out;
    logic [CNT_OUT_W-1:0]  count_after;
    logic                  freed;
    logic [FREE_OUT_W-1:0] free_slots;

    modport source (output valid, output status, output slot_out, output count_after,
                    output freed, output free_slots, input ready);
    modport sink   (input valid, input status, input slot_out, input count_after,
                    input freed, input free_slots, output ready);

endinterface

@@ hdl/refcounted_block_pool.sv @@
// reference-counted buffer pool: slot allocation over a linked free list
//
// Requests arrive on req (func, slot_in) and each gives exactly one beat on
// rsp. A get pops the head of the free list and gives the slot a count of
// one, a ref adds one to a slot's count, a put removes one and pushes the
// slot back on the free list when the count falls to zero.
// An accepted beat reads the count and link memories at that edge; in the
// execute state the block then applies the operation, writes back and
// loads the response register that drives rsp.valid. A new request is taken
// only in the idle state, so only after the last one has been written back.
// A request is taken while an earlier response still waits on rsp; if that
// response is not taken, the block holds the new operation and its writes
// until the response register frees up.
// Reset empties the pipeline and puts every slot on the free list in order.
// The memories are not cleared: a fill mark counts the slots ever handed
// out, and entries at or above it read as never written (count zero, link
// to the following slot), so the block is ready right after reset.
module refcounted_block_pool import rcbp_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    rcbp_req_if.sink   req,
    rcbp_rsp_if.source rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam int HW = SW + 1;
    localparam int CW = COUNT_BITS;
    localparam int XW = HW + SLOT_W;
    localparam int KW = CW + CNT_OUT_W;
    localparam int TW = HW + FREE_OUT_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                  state_reg, state_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [HW-1:0]         head_reg, head_next;
    logic [HW-1:0]         total_reg, total_next;
    logic [HW-1:0]         fresh_reg, fresh_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_W-1:0]     slot_out_reg, slot_out_next;
    logic [CNT_OUT_W-1:0]  count_reg, count_next;
    logic                  freed_reg, freed_next;
    logic [FREE_OUT_W-1:0] free_slots_reg, free_slots_next;

    logic                  accept;
    logic                  exec_go;
    logic [XW-1:0]         in_ext;
    logic [CW-1:0]         rd_cnt;
    logic [HW-1:0]         rd_link;

    logic [XW-1:0]         slot_ext;
    logic [XW-1:0]         head_ext;
    logic [SW-1:0]         slot_addr;
    logic                  slot_used;
    logic [CW-1:0]         cur;
    logic                  head_ok;
    logic [HW-1:0]         link_val;
    logic [CW-1:0]         count_res;
    logic [KW-1:0]         count_ext;
    logic [TW-1:0]         total_ext;

    logic                  cnt_we;
    logic [SW-1:0]         cnt_waddr;
    logic [CW-1:0]         cnt_wdata;
    logic                  link_we;

    // handshake
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign in_ext    = XW'(req.slot_in);

    // reference counts
    rcbp_ram #(
        .WIDTH (CW),
        .DEPTH (SLOTS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (accept),
        .raddr (in_ext[SW-1:0]),
        .rdata (rd_cnt)
    );

    // free list links
    rcbp_ram #(
        .WIDTH (HW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (slot_addr),
        .wdata (head_reg),
        .re    (accept),
        .raddr (head_reg[SW-1:0]),
        .rdata (rd_link)
    );

    // operand decode, untouched entries read as their reset value
    always_comb
    begin
        slot_ext  = XW'(slot_reg);
        head_ext  = XW'(head_reg);
        slot_addr = slot_ext[SW-1:0];
        slot_used = (slot_ext < XW'(SLOTS)) && (slot_ext < XW'(fresh_reg));
        cur       = slot_used ? rd_cnt : '0;
        head_ok   = (total_reg != '0) && (head_reg < HW'(SLOTS));
        link_val  = (head_reg < fresh_reg) ? rd_link : head_reg + HW'(1);
    end

    // operation
    always_comb
    begin
        head_next     = head_reg;
        total_next    = total_reg;
        fresh_next    = fresh_reg;
        status_next   = STAT_OK;
        slot_out_next = slot_reg;
        count_res     = '0;
        freed_next    = 1'b0;
        cnt_we        = 1'b0;
        cnt_waddr     = slot_addr;
        cnt_wdata     = '0;
        link_we       = 1'b0;

        case (func_reg)
            FUNC_GET:
            begin
                if (!head_ok)
                begin
                    status_next   = STAT_EMPTY;
                    slot_out_next = '0;
                end
                else
                begin
                    head_next     = link_val;
                    total_next    = total_reg - HW'(1);
                    slot_out_next = head_ext[SLOT_W-1:0];
                    count_res     = CW'(1);
                    cnt_we        = exec_go;
                    cnt_waddr     = head_reg[SW-1:0];
                    cnt_wdata     = CW'(1);
                    if (head_reg == fresh_reg)
                    begin
                        fresh_next = fresh_reg + HW'(1);
                    end
                end
            end
            FUNC_REF:
            begin
                if (cur == '0)
                begin
                    status_next = STAT_NOT_IN_USE;
                end
                else if (cur == '1)
                begin
                    status_next = STAT_SATURATED;
                    count_res   = cur;
                end
                else
                begin
                    count_res = cur + CW'(1);
                    cnt_we    = exec_go;
                    cnt_wdata = cur + CW'(1);
                end
            end
            FUNC_PUT:
            begin
                if (cur == '0)
                begin
                    status_next = STAT_NOT_IN_USE;
                end
                else
                begin
                    count_res = cur - CW'(1);
                    cnt_we    = exec_go;
                    cnt_wdata = cur - CW'(1);
                    if (cur == CW'(1))
                    begin
                        link_we    = exec_go;
                        head_next  = slot_ext[HW-1:0];
                        freed_next = 1'b1;
                        if (total_reg < HW'(SLOTS))
                        begin
                            total_next = total_reg + HW'(1);
                        end
                    end
                end
            end
            default:
            begin
                count_res = cur;
            end
        endcase

        count_ext       = KW'(count_res);
        total_ext       = TW'(total_next);
        count_next      = count_ext[CNT_OUT_W-1:0];
        free_slots_next = total_ext[FREE_OUT_W-1:0];
    end

    // sequencing and response valid
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            head_reg      <= '0;
            total_reg     <= HW'(SLOTS);
            fresh_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_go)
            begin
                head_reg  <= head_next;
                total_reg <= total_next;
                fresh_reg <= fresh_next;
            end
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            slot_reg <= req.slot_in;
        end
        if (exec_go)
        begin
            status_reg     <= status_next;
            slot_out_reg   <= slot_out_next;
            count_reg      <= count_next;
            freed_reg      <= freed_next;
            free_slots_reg <= free_slots_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.slot_out    = slot_out_reg;
    assign rsp.count_after = count_reg;
    assign rsp.freed       = freed_reg;
    assign rsp.free_slots  = free_slots_reg;

endmodule

@@ hdl/rcbp_ram.sv @@
// simple dual-port memory, one write port and one registered read port
module rcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench of the reference-counted block pool with a cycle-free predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcbp_pkg::*;

    localparam int NSLOTS       = DEF_SLOTS;
    localparam int CBITS        = DEF_COUNT_BITS;
    localparam int RANDOM_ITEMS = 590;
    localparam int DEEP_REFS    = 24;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PRINT_CAP    = 50;

    // the one func code the package leaves unnamed: no operation
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    localparam longint unsigned COUNT_MAX = (64'd1 << CBITS) - 64'd1;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_W-1:0]     slot;
        logic [CNT_OUT_W-1:0]  count;
        logic                  freed;
        logic [FREE_OUT_W-1:0] free_slots;
    } pool_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    rcbp_req_if req ();
    rcbp_rsp_if rsp ();

    refcounted_block_pool #(
        .SLOTS      (NSLOTS),
        .COUNT_BITS (CBITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // predicted pool state
    int unsigned     pool_head;
    int unsigned     pool_link [NSLOTS];
    longint unsigned pool_refs [NSLOTS];
    int unsigned     pool_free;

    pool_rsp_t pending_rsp [$];

    bit no_idle;
    bit ready_level;
    int ready_run;
    int idle_cycles;
    int errors;
    int n_sent;
    int n_checked;
    int n_freed;
    int status_seen [4];

    // pool state right after reset
    function automatic void pool_clear();
        for (int i = 0; i < NSLOTS; i++)
        begin
            pool_link[i] = i + 1;
            pool_refs[i] = 0;
        end
        pool_head = 0;
        pool_free = NSLOTS;
    endfunction

    // apply one operation to the predicted state and return its response
    function automatic pool_rsp_t pool_apply(logic [FUNC_W-1:0] op, logic [SLOT_W-1:0] s);
        pool_rsp_t       r;
        longint unsigned cur;
        int unsigned     idx;
        idx          = s;
        r.status     = STAT_OK;
        r.slot       = s;
        r.count      = '0;
        r.freed      = 1'b0;
        cur          = (idx < NSLOTS) ? pool_refs[idx] : 0;
        case (op)
            FUNC_GET:
            begin
                if (pool_free == 0 || pool_head >= NSLOTS)
                begin
                    r.status = STAT_EMPTY;
                    r.slot   = '0;
                end
                else
                begin
                    idx            = pool_head;
                    pool_head      = pool_link[idx];
                    pool_refs[idx] = 1;
                    pool_free--;
                    r.slot         = idx[SLOT_W-1:0];
                    r.count        = CNT_OUT_W'(1);
                end
            end
            FUNC_REF:
            begin
                if (idx >= NSLOTS || cur == 0)
                    r.status = STAT_NOT_IN_USE;
                else if (cur >= COUNT_MAX)
                begin
                    r.status = STAT_SATURATED;
                    r.count  = cur[CNT_OUT_W-1:0];
                end
                else
                begin
                    pool_refs[idx] = cur + 1;
                    r.count        = cur[CNT_OUT_W-1:0] + 1'b1;
                end
            end
            FUNC_PUT:
            begin
                if (idx >= NSLOTS || cur == 0)
                    r.status = STAT_NOT_IN_USE;
                else
                begin
                    pool_refs[idx] = cur - 1;
                    r.count        = cur[CNT_OUT_W-1:0] - 1'b1;
                    if (cur == 1)
                    begin
                        pool_link[idx] = pool_head;
                        pool_head      = idx;
                        if (pool_free < NSLOTS)
                            pool_free++;
                        r.freed = 1'b1;
                    end
                end
            end
            default: r.count = cur[CNT_OUT_W-1:0];
        endcase
        r.free_slots = pool_free[FREE_OUT_W-1:0];
        return r;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // random slot that the predictor holds in use
    function automatic bit pick_in_use(output logic [SLOT_W-1:0] s);
        int held [$];
        for (int i = 0; i < NSLOTS; i++)
            if (pool_refs[i] != 0)
                held.push_back(i);
        s = '0;
        if (held.size() == 0)
            return 1'b0;
        s = SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h",
                     $realtime, what, got, want);
    endtask

    // drive one request beat and record its predicted response
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [SLOT_W-1:0] s);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.func    <= op;
        req.slot_in <= s;
        do
            @(posedge clk);
        while (!req.ready);
        pending_rsp.push_back(pool_apply(op, s));
        n_sent++;
    endtask

    // hold off the sender until every response is in
    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // extremes of slot_in, every func code, the not-in-use error
    task automatic test_directed();
        send_op(FUNC_GET, 8'hFF);
        send_op(FUNC_GET, 8'h00);
        send_op(FUNC_REF, 8'h00);
        send_op(FUNC_REF, 8'hFF);
        send_op(FUNC_PUT, 8'h01);
        send_op(FUNC_PUT, 8'h01);
        send_op(FUNC_NOP, 8'h00);
        send_op(FUNC_NOP, 8'hFF);
        send_op(FUNC_PUT, 8'h00);
        send_op(FUNC_PUT, 8'h00);
        send_op(FUNC_REF, 8'h00);
        send_op(FUNC_GET, 8'hAA);
        send_op(FUNC_GET, 8'h55);
        send_op(FUNC_PUT, 8'h00);
        send_op(FUNC_PUT, 8'h01);
    endtask

    // climb one slot to a deep count back to back, then step it down and up
    task automatic test_deep_refs();
        logic [SLOT_W-1:0] held;
        held    = pool_head[SLOT_W-1:0];
        no_idle = 1'b1;
        send_op(FUNC_GET, SLOT_W'($urandom_range(0, NSLOTS - 1)));
        while (pool_refs[held] < DEEP_REFS)
            send_op(FUNC_REF, held);
        no_idle = 1'b0;
        send_op(FUNC_REF, held);
        send_op(FUNC_NOP, held);
        send_op(FUNC_PUT, held);
        send_op(FUNC_REF, held);
        send_op(FUNC_REF, held);
        send_op(FUNC_PUT, held);
    endtask

    // run the pool dry, ask twice more, then release in scrambled order
    task automatic test_exhaustion();
        int order [$];
        int j;
        int t;
        while (pool_free != 0)
            send_op(FUNC_GET, SLOT_W'($urandom_range(0, NSLOTS - 1)));
        send_op(FUNC_GET, 8'hFF);
        send_op(FUNC_GET, 8'h00);
        wait_drained();
        for (int i = 0; i < NSLOTS; i++)
            if (pool_refs[i] == 1)
                order.push_back(i);
        for (int i = order.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[k])
            send_op(FUNC_PUT, order[k][SLOT_W-1:0]);
    endtask

    // phases that fill or drain the pool, with noise beats mixed in
    task automatic test_random(input int items);
        int                fill_bias;
        int                phase_left;
        int                r;
        logic [SLOT_W-1:0] s;
        phase_left = 0;
        fill_bias  = 50;
        for (int i = 0; i < items; i++)
        begin
            if (phase_left == 0)
            begin
                fill_bias  = $urandom_range(0, 1) ? 65 : 20;
                phase_left = $urandom_range(30, 150);
                no_idle    = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            if ($urandom_range(0, 199) == 0)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 8)
                send_op(FUNC_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, NSLOTS - 1)));
            else
            begin
                r = $urandom_range(0, 99);
                if (!pick_in_use(s) || r < fill_bias)
                    send_op(FUNC_GET, SLOT_W'($urandom_range(0, NSLOTS - 1)));
                else if (r < fill_bias + (100 - fill_bias) / 3)
                    send_op(FUNC_REF, s);
                else
                    send_op(FUNC_PUT, s);
            end
        end
        no_idle = 1'b0;
    endtask

    // response side: ready high for a run, then a stall of random length
    always @(posedge clk)
    begin
        if (ready_run <= 0)
        begin
            if (ready_level)
            begin
                ready_run = pick_gap();
                if (ready_run > 0)
                    ready_level = 1'b0;
                else
                    ready_run = $urandom_range(1, 16);
            end
            else
            begin
                ready_level = 1'b1;
                ready_run   = $urandom_range(1, 16);
            end
        end
        ready_run--;
        rsp.ready <= no_idle || ready_level;
    end

    // compare each response beat with the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        pool_rsp_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected beat, slot_out", rsp.slot_out, 0);
            else
            begin
                want = pending_rsp.pop_front();
                n_checked++;
                status_seen[want.status]++;
                if (want.freed)
                    n_freed++;
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.slot_out !== want.slot)
                    report_mismatch("slot_out", rsp.slot_out, want.slot);
                if (rsp.count_after !== want.count)
                    report_mismatch("count_after", rsp.count_after, want.count);
                if (rsp.freed !== want.freed)
                    report_mismatch("freed", rsp.freed, want.freed);
                if (rsp.free_slots !== want.free_slots)
                    report_mismatch("free_slots", rsp.free_slots, want.free_slots);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                     idle_cycles, pending_rsp.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        req.valid   <= 1'b0;
        req.func    <= FUNC_GET;
        req.slot_in <= '0;
        pool_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_deep_refs();
        test_exhaustion();
        test_random(RANDOM_ITEMS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d responses checked", n_sent, n_checked);
        $display("ok %0d, empty %0d, not in use %0d, saturated %0d, freed %0d, mismatches %0d",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY],
                 status_seen[STAT_NOT_IN_USE], status_seen[STAT_SATURATED],
                 n_freed, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
